>>> rtl/whw_pkg.sv
// Shared types, constants and helpers for the worker heartbeat watchdog.
// Used by whw_ctrl, whw_dp and the top level worker_heartbeat_watchdog.
package whw_pkg;

    // Sizing of the watchdog bank
    localparam int NUM_WORKERS = 16;
    localparam int TIME_BITS   = 32;
    localparam int SLOT_W      = (NUM_WORKERS > 1) ? $clog2(NUM_WORKERS) : 1;
    localparam int COUNT_W     = $clog2(NUM_WORKERS + 1);

    // Fixed field widths of the request and result words
    localparam int REQ_W       = 3;
    localparam int WORKER_W    = 4;
    localparam int GRACE_W     = 30;
    localparam int OUT_CNT_W   = 5;

    // Request codes
    typedef enum logic [REQ_W-1:0] {
        REQ_TICK   = 3'd0,
        REQ_ADD    = 3'd1,
        REQ_REMOVE = 3'd2,
        REQ_ARM    = 3'd3,
        REQ_DISARM = 3'd4,
        REQ_CHECK  = 3'd5,
        REQ_INJECT = 3'd6,
        REQ_NOP    = 3'd7
    } req_t;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_DONE
    } ctrl_state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;        // capture an incoming request word
        logic exec;        // carry out a request other than a health check
        logic scan_start;  // open a health check
        logic scan_step;   // examine one slot of the health check
        logic out_load;    // move the result into the output register
    } dp_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic is_check;    // captured request is a health check
        logic scan_last;   // scan is at the final slot
        logic fatal;       // sticky fatal flag
    } dp_stat_t;

    // True when a is strictly later than b in wrapping time
    function automatic logic later(input logic [TIME_BITS-1:0] a,
                                   input logic [TIME_BITS-1:0] b);
        logic [TIME_BITS-1:0] d;
        d = a - b;
        return (d != '0) && !d[TIME_BITS-1];
    endfunction

endpackage

>>> rtl/whw_ctrl.sv
// Sequencer for the worker heartbeat watchdog: handshakes and step order.
// Depends on whw_pkg; drives the command struct of whw_dp.
module whw_ctrl
    import whw_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    output logic     out_valid,
    input  logic     out_stall,
    output dp_cmd_t  cmd,
    input  dp_stat_t stat
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        out_valid_reg;
    logic        out_valid_next;

    // Hold state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Advance through the steps of one request
    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        in_stall       = 1'b1;
        out_valid_next = out_valid_reg && out_stall;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (stat.is_check)
                begin
                    cmd.scan_start = 1'b1;
                    state_next     = ST_SCAN;
                end
                else
                begin
                    cmd.exec   = 1'b1;
                    state_next = ST_DONE;
                end
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (stat.scan_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                // Hand the word over once the output register is free
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule

>>> rtl/whw_dp.sv
// Datapath of the worker heartbeat watchdog: time base, slot bank, scan
// counters and the output word register. Depends on whw_pkg.
module whw_dp
    import whw_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [REQ_W-1:0]     req_type,
    input  logic [WORKER_W-1:0]  worker,
    input  logic [GRACE_W-1:0]   grace_ticks,
    input  logic [GRACE_W-1:0]   suicide_ticks,
    input  dp_cmd_t              cmd,
    output dp_stat_t             stat,
    output logic                 healthy,
    output logic [OUT_CNT_W-1:0] unhealthy_count,
    output logic [OUT_CNT_W-1:0] total_count,
    output logic                 fatal,
    output logic [WORKER_W-1:0]  fatal_worker,
    output logic                 status
);

    // Captured request word
    req_t                 req_reg;
    logic [WORKER_W-1:0]  worker_reg;
    logic [GRACE_W-1:0]   grace_reg;
    logic [GRACE_W-1:0]   suicide_reg;

    // Watchdog state
    logic [TIME_BITS-1:0]   now_reg, now_next;
    logic [NUM_WORKERS-1:0] active_reg, active_next;
    logic [NUM_WORKERS-1:0] soft_arm_reg, soft_arm_next;
    logic [NUM_WORKERS-1:0] hard_arm_reg, hard_arm_next;
    logic [TIME_BITS-1:0]   soft_dl_reg [NUM_WORKERS];
    logic [TIME_BITS-1:0]   hard_dl_reg [NUM_WORKERS];
    logic                   soft_we;
    logic                   hard_we;
    logic [TIME_BITS-1:0]   inject_until_reg, inject_until_next;
    logic                   inject_arm_reg, inject_arm_next;
    logic                   last_healthy_reg, last_healthy_next;
    logic [COUNT_W-1:0]     last_bad_reg, last_bad_next;
    logic [COUNT_W-1:0]     last_total_reg, last_total_next;
    logic                   fatal_reg, fatal_next;
    logic [WORKER_W-1:0]    fatal_slot_reg, fatal_slot_next;
    logic                   status_reg, status_next;

    // Scan working registers
    logic                   ok_reg, ok_next;
    logic [COUNT_W-1:0]     bad_reg, bad_next;
    logic [COUNT_W-1:0]     total_reg, total_next;
    logic [SLOT_W-1:0]      idx_reg, idx_next;

    // Output word register
    logic                   healthy_reg;
    logic [OUT_CNT_W-1:0]   unhealthy_out_reg;
    logic [OUT_CNT_W-1:0]   total_out_reg;
    logic                   fatal_out_reg;
    logic [WORKER_W-1:0]    fatal_worker_out_reg;
    logic                   status_out_reg;

    // Shared slot lookup
    logic [SLOT_W-1:0]      slot;
    logic                   slot_ok;
    logic                   slot_act;
    logic [SLOT_W-1:0]      rd_idx;
    logic                   hard_hit;
    logic                   soft_hit;
    logic [TIME_BITS-1:0]   soft_sum;
    logic [TIME_BITS-1:0]   hard_sum;
    logic                   scan_last;

    assign slot      = SLOT_W'(worker_reg);
    assign slot_ok   = int'(worker_reg) < NUM_WORKERS;
    assign slot_act  = slot_ok && active_reg[slot];
    assign rd_idx    = cmd.scan_step ? idx_reg : slot;
    assign hard_hit  = hard_arm_reg[rd_idx] && later(now_reg, hard_dl_reg[rd_idx]);
    assign soft_hit  = soft_arm_reg[rd_idx] && later(now_reg, soft_dl_reg[rd_idx]);
    assign soft_sum  = now_reg + TIME_BITS'(grace_reg);
    assign hard_sum  = now_reg + TIME_BITS'(suicide_reg);
    assign scan_last = idx_reg == SLOT_W'(NUM_WORKERS - 1);

    // Work out the next state for the current command
    always_comb
    begin
        now_next          = now_reg;
        active_next       = active_reg;
        soft_arm_next     = soft_arm_reg;
        hard_arm_next     = hard_arm_reg;
        soft_we           = 1'b0;
        hard_we           = 1'b0;
        inject_until_next = inject_until_reg;
        inject_arm_next   = inject_arm_reg;
        last_healthy_next = last_healthy_reg;
        last_bad_next     = last_bad_reg;
        last_total_next   = last_total_reg;
        fatal_next        = fatal_reg;
        fatal_slot_next   = fatal_slot_reg;
        status_next       = status_reg;
        ok_next           = ok_reg;
        bad_next          = bad_reg;
        total_next        = total_reg;
        idx_next          = idx_reg;

        // Requests other than a health check
        if (cmd.exec)
        begin
            status_next = 1'b0;
            unique case (req_reg)
                REQ_TICK:
                begin
                    now_next = now_reg + TIME_BITS'(1);
                end
                REQ_ADD:
                begin
                    if (!slot_ok || slot_act)
                    begin
                        status_next = 1'b1;
                    end
                    else
                    begin
                        active_next[slot]   = 1'b1;
                        soft_arm_next[slot] = 1'b0;
                        hard_arm_next[slot] = 1'b0;
                    end
                end
                REQ_REMOVE:
                begin
                    if (!slot_act)
                    begin
                        status_next = 1'b1;
                    end
                    else
                    begin
                        active_next[slot]   = 1'b0;
                        soft_arm_next[slot] = 1'b0;
                        hard_arm_next[slot] = 1'b0;
                    end
                end
                REQ_ARM:
                begin
                    if (!slot_act)
                    begin
                        status_next = 1'b1;
                    end
                    else
                    begin
                        if (hard_hit && !fatal_reg)
                        begin
                            fatal_next      = 1'b1;
                            fatal_slot_next = WORKER_W'(rd_idx);
                        end
                        soft_we             = 1'b1;
                        soft_arm_next[slot] = 1'b1;
                        hard_we             = suicide_reg != '0;
                        hard_arm_next[slot] = suicide_reg != '0;
                    end
                end
                REQ_DISARM:
                begin
                    if (!slot_act)
                    begin
                        status_next = 1'b1;
                    end
                    else
                    begin
                        if (hard_hit && !fatal_reg)
                        begin
                            fatal_next      = 1'b1;
                            fatal_slot_next = WORKER_W'(rd_idx);
                        end
                        soft_arm_next[slot] = 1'b0;
                        hard_arm_next[slot] = 1'b0;
                    end
                end
                REQ_INJECT:
                begin
                    if (grace_reg != '0)
                    begin
                        inject_until_next = soft_sum;
                        inject_arm_next   = 1'b1;
                    end
                end
                REQ_CHECK,
                REQ_NOP:
                begin
                end
            endcase
        end

        // Open a health check: judge the pending injection, clear counters
        if (cmd.scan_start)
        begin
            status_next = 1'b0;
            ok_next     = 1'b1;
            bad_next    = '0;
            total_next  = '0;
            idx_next    = '0;
            if (inject_arm_reg)
            begin
                if (later(inject_until_reg, now_reg))
                begin
                    ok_next = 1'b0;
                end
                else
                begin
                    inject_arm_next = 1'b0;
                end
            end
        end

        // Examine one slot; lowest slot latches fatal first
        if (cmd.scan_step)
        begin
            if (active_reg[idx_reg])
            begin
                if (soft_hit)
                begin
                    ok_next  = 1'b0;
                    bad_next = bad_reg + COUNT_W'(1);
                end
                if (hard_hit && !fatal_reg)
                begin
                    fatal_next      = 1'b1;
                    fatal_slot_next = WORKER_W'(idx_reg);
                end
                total_next = total_reg + COUNT_W'(1);
            end
            idx_next = idx_reg + SLOT_W'(1);
            if (scan_last)
            begin
                last_healthy_next = ok_next;
                last_bad_next     = bad_next;
                last_total_next   = total_next;
            end
        end
    end

    // Hold control and watchdog state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            now_reg          <= '0;
            active_reg       <= '0;
            soft_arm_reg     <= '0;
            hard_arm_reg     <= '0;
            inject_until_reg <= '0;
            inject_arm_reg   <= 1'b0;
            last_healthy_reg <= 1'b1;
            last_bad_reg     <= '0;
            last_total_reg   <= '0;
            fatal_reg        <= 1'b0;
            fatal_slot_reg   <= '0;
            status_reg       <= 1'b0;
            ok_reg           <= 1'b1;
            bad_reg          <= '0;
            total_reg        <= '0;
            idx_reg          <= '0;
        end
        else
        begin
            now_reg          <= now_next;
            active_reg       <= active_next;
            soft_arm_reg     <= soft_arm_next;
            hard_arm_reg     <= hard_arm_next;
            inject_until_reg <= inject_until_next;
            inject_arm_reg   <= inject_arm_next;
            last_healthy_reg <= last_healthy_next;
            last_bad_reg     <= last_bad_next;
            last_total_reg   <= last_total_next;
            fatal_reg        <= fatal_next;
            fatal_slot_reg   <= fatal_slot_next;
            status_reg       <= status_next;
            ok_reg           <= ok_next;
            bad_reg          <= bad_next;
            total_reg        <= total_next;
            idx_reg          <= idx_next;
        end
    end

    // Capture the request word and write deadlines
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg     <= req_t'(req_type);
            worker_reg  <= worker;
            grace_reg   <= grace_ticks;
            suicide_reg <= suicide_ticks;
        end
        if (soft_we)
        begin
            soft_dl_reg[slot] <= soft_sum;
        end
        if (hard_we)
        begin
            hard_dl_reg[slot] <= hard_sum;
        end
    end

    // Load the output word
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            healthy_reg          <= last_healthy_reg;
            unhealthy_out_reg    <= OUT_CNT_W'(last_bad_reg);
            total_out_reg        <= OUT_CNT_W'(last_total_reg);
            fatal_out_reg        <= fatal_reg;
            fatal_worker_out_reg <= fatal_slot_reg;
            status_out_reg       <= status_reg;
        end
    end

    assign stat.is_check   = req_reg == REQ_CHECK;
    assign stat.scan_last  = scan_last;
    assign stat.fatal      = fatal_reg;

    assign healthy         = healthy_reg;
    assign unhealthy_count = unhealthy_out_reg;
    assign total_count     = total_out_reg;
    assign fatal           = fatal_out_reg;
    assign fatal_worker    = fatal_worker_out_reg;
    assign status          = status_out_reg;

endmodule

>>> rtl/worker_heartbeat_watchdog.sv
// Tick, add, remove, arm, disarm and inject take the exec step on their way to the result;
// a health check instead walks the 16 slots one a cycle through a shared slot lookup with
// its soft and hard deadline compares. One word is in flight at a time: no new word is
// taken before the last one's result has been loaded into the output register.
// Reset (rst_n, async, active low) clears time, slot flags, injection, fatal and the
// last check results; deadline stores are left as is and read only while armed.
module worker_heartbeat_watchdog
    import whw_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [REQ_W-1:0]     req_type,
    input  logic [WORKER_W-1:0]  worker,
    input  logic [GRACE_W-1:0]   grace_ticks,
    input  logic [GRACE_W-1:0]   suicide_ticks,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic                 healthy,
    output logic [OUT_CNT_W-1:0] unhealthy_count,
    output logic [OUT_CNT_W-1:0] total_count,
    output logic                 fatal,
    output logic [WORKER_W-1:0]  fatal_worker,
    output logic                 status
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // Sequencer
    whw_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .stat      (stat)
    );

    // Datapath
    whw_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .req_type        (req_type),
        .worker          (worker),
        .grace_ticks     (grace_ticks),
        .suicide_ticks   (suicide_ticks),
        .cmd             (cmd),
        .stat            (stat),
        .healthy         (healthy),
        .unhealthy_count (unhealthy_count),
        .total_count     (total_count),
        .fatal           (fatal),
        .fatal_worker    (fatal_worker),
        .status          (status)
    );

    // Fatal flag never drops once latched
    a_fatal_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        stat.fatal |=> stat.fatal)
        else $error("fatal flag dropped");

    // An accepted word keeps the input side busy in the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input taken while a word is in progress");

    // Soft expiries never exceed active slots and always mean unhealthy
    a_counts_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (unhealthy_count <= total_count) &&
                      ((unhealthy_count == '0) || !healthy))
        else $error("health check counts inconsistent");

    // Fatal slot stays zero while no fatal is latched
    a_fatal_slot_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !fatal) |-> (fatal_worker == '0))
        else $error("fatal slot set without fatal");

endmodule

>>> tb/worker_heartbeat_watchdog_chk.sv
// Checker for worker_heartbeat_watchdog: watches both word channels, predicts each
// result from its own copy of the watchdog state and compares field by field.
// Depends on whw_pkg for the request codes and field widths.
`timescale 1ns / 1ps

module worker_heartbeat_watchdog_chk
    import whw_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_stall,
    input  logic [REQ_W-1:0]     req_type,
    input  logic [WORKER_W-1:0]  worker,
    input  logic [GRACE_W-1:0]   grace_ticks,
    input  logic [GRACE_W-1:0]   suicide_ticks,
    input  logic                 out_valid,
    input  logic                 out_stall,
    input  logic                 healthy,
    input  logic [OUT_CNT_W-1:0] unhealthy_count,
    input  logic [OUT_CNT_W-1:0] total_count,
    input  logic                 fatal,
    input  logic [WORKER_W-1:0]  fatal_worker,
    input  logic                 status,
    output int                   mismatches,
    output int                   outstanding,
    output int                   compared
);

    typedef struct {
        logic                 healthy;
        logic [OUT_CNT_W-1:0] unhealthy;
        logic [OUT_CNT_W-1:0] total;
        logic                 fatal;
        logic [WORKER_W-1:0]  fatal_slot;
        logic                 status;
    } wd_result_t;

    // Predicted watchdog state
    logic [TIME_BITS-1:0]   now_t;
    logic [NUM_WORKERS-1:0] slot_on;
    logic [NUM_WORKERS-1:0] soft_on;
    logic [NUM_WORKERS-1:0] hard_on;
    logic [TIME_BITS-1:0]   soft_due [NUM_WORKERS];
    logic [TIME_BITS-1:0]   hard_due [NUM_WORKERS];
    logic [TIME_BITS-1:0]   inject_due;
    logic                   inject_on;
    logic                   last_ok;
    logic [OUT_CNT_W-1:0]   last_bad;
    logic [OUT_CNT_W-1:0]   last_total;
    logic                   fatal_on;
    logic [WORKER_W-1:0]    fatal_id;

    wd_result_t results_due [$];
    int         err_total = 0;
    int         done_total = 0;

    // a strictly later than b, by signed wrapping difference
    function automatic logic is_past(input logic [TIME_BITS-1:0] a,
                                     input logic [TIME_BITS-1:0] b);
        logic [TIME_BITS-1:0] diff;
        diff = a - b;
        return (diff != '0) && (diff[TIME_BITS-1] == 1'b0);
    endfunction

    // Latch fatal on the first expired hard deadline
    function automatic void latch_hard(input int slot);
        if (hard_on[slot] && is_past(now_t, hard_due[slot]) && !fatal_on)
        begin
            fatal_on = 1'b1;
            fatal_id = WORKER_W'(slot);
        end
    endfunction

    // Apply one request word and return the result it produces
    function automatic wd_result_t watchdog_step(input req_t req,
                                                 input logic [WORKER_W-1:0] w,
                                                 input logic [GRACE_W-1:0] grace,
                                                 input logic [GRACE_W-1:0] hard_grace);
        wd_result_t res;
        logic       ok;
        int         bad;
        int         cnt;
        logic       bad_slot;
        bad_slot = 1'b0;
        case (req)
            REQ_TICK:
                now_t = now_t + TIME_BITS'(1);
            REQ_ADD:
                if (slot_on[w])
                    bad_slot = 1'b1;
                else
                begin
                    slot_on[w] = 1'b1;
                    soft_on[w] = 1'b0;
                    hard_on[w] = 1'b0;
                end
            REQ_REMOVE:
                if (!slot_on[w])
                    bad_slot = 1'b1;
                else
                begin
                    slot_on[w] = 1'b0;
                    soft_on[w] = 1'b0;
                    hard_on[w] = 1'b0;
                end
            REQ_ARM:
                if (!slot_on[w])
                    bad_slot = 1'b1;
                else
                begin
                    latch_hard(w);
                    soft_due[w] = now_t + TIME_BITS'(grace);
                    soft_on[w]  = 1'b1;
                    hard_on[w]  = (hard_grace != '0);
                    if (hard_grace != '0)
                        hard_due[w] = now_t + TIME_BITS'(hard_grace);
                end
            REQ_DISARM:
                if (!slot_on[w])
                    bad_slot = 1'b1;
                else
                begin
                    latch_hard(w);
                    soft_on[w] = 1'b0;
                    hard_on[w] = 1'b0;
                end
            REQ_CHECK:
            begin
                ok  = 1'b1;
                bad = 0;
                cnt = 0;
                // unhealthy while an injection is still pending, else drop the injection
                if (inject_on)
                begin
                    if (is_past(inject_due, now_t))
                        ok = 1'b0;
                    else
                        inject_on = 1'b0;
                end
                for (int i = 0; i < NUM_WORKERS; i++)
                begin
                    if (slot_on[i])
                    begin
                        if (soft_on[i] && is_past(now_t, soft_due[i]))
                        begin
                            ok = 1'b0;
                            bad++;
                        end
                        latch_hard(i);
                        cnt++;
                    end
                end
                last_ok    = ok;
                last_bad   = OUT_CNT_W'(bad);
                last_total = OUT_CNT_W'(cnt);
            end
            REQ_INJECT:
                if (grace != '0)
                begin
                    inject_due = now_t + TIME_BITS'(grace);
                    inject_on  = 1'b1;
                end
            default:
                ;
        endcase
        res.healthy    = last_ok;
        res.unhealthy  = last_bad;
        res.total      = last_total;
        res.fatal      = fatal_on;
        res.fatal_slot = fatal_id;
        res.status     = bad_slot;
        return res;
    endfunction

    function automatic void check_field(input string label, input int unsigned want,
                                        input int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
            err_total++;
        end
    endfunction

    // Track both channels; compare the result first, then take the new word
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            now_t       = '0;
            slot_on     = '0;
            soft_on     = '0;
            hard_on     = '0;
            inject_due  = '0;
            inject_on   = 1'b0;
            last_ok     = 1'b1;
            last_bad    = '0;
            last_total  = '0;
            fatal_on    = 1'b0;
            fatal_id    = '0;
            results_due.delete();
            mismatches  <= 0;
            outstanding <= 0;
            compared    <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (results_due.size() == 0)
                begin
                    $display("%0t: result word with none expected, actual healthy %0d status %0d",
                             $time, healthy, status);
                    err_total++;
                end
                else
                begin
                    wd_result_t want;
                    want = results_due.pop_front();
                    check_field("healthy", want.healthy, healthy);
                    check_field("unhealthy_count", want.unhealthy, unhealthy_count);
                    check_field("total_count", want.total, total_count);
                    check_field("fatal", want.fatal, fatal);
                    check_field("fatal_worker", want.fatal_slot, fatal_worker);
                    check_field("status", want.status, status);
                    done_total++;
                end
            end
            if (in_valid && !in_stall)
                results_due.push_back(watchdog_step(req_t'(req_type), worker,
                                                    grace_ticks, suicide_ticks));
            mismatches  <= err_total;
            outstanding <= results_due.size();
            compared    <= done_total;
        end
    end

endmodule

>>> tb/worker_heartbeat_watchdog_tb.sv
// Top of the worker_heartbeat_watchdog testbench: clock, reset, request stimulus with
// random idling on both channels, and the verdict. Depends on whw_pkg, the block and
// the checker in worker_heartbeat_watchdog_chk.sv.
`timescale 1ns / 1ps

module worker_heartbeat_watchdog_tb;
    import whw_pkg::*;

    localparam int                 RANDOM_WORDS = 550;
    localparam logic [GRACE_W-1:0] GRACE_MAX    = '1;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    logic [REQ_W-1:0]     req_type;
    logic [WORKER_W-1:0]  worker;
    logic [GRACE_W-1:0]   grace_ticks;
    logic [GRACE_W-1:0]   suicide_ticks;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic                 healthy;
    logic [OUT_CNT_W-1:0] unhealthy_count;
    logic [OUT_CNT_W-1:0] total_count;
    logic                 fatal;
    logic [WORKER_W-1:0]  fatal_worker;
    logic                 status;

    int mismatches;
    int outstanding;
    int compared;
    int stall_left = 0;
    bit calm = 1'b0;
    int sent_by_req [8];

    worker_heartbeat_watchdog dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .req_type        (req_type),
        .worker          (worker),
        .grace_ticks     (grace_ticks),
        .suicide_ticks   (suicide_ticks),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .healthy         (healthy),
        .unhealthy_count (unhealthy_count),
        .total_count     (total_count),
        .fatal           (fatal),
        .fatal_worker    (fatal_worker),
        .status          (status)
    );

    worker_heartbeat_watchdog_chk hb_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .req_type        (req_type),
        .worker          (worker),
        .grace_ticks     (grace_ticks),
        .suicide_ticks   (suicide_ticks),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .healthy         (healthy),
        .unhealthy_count (unhealthy_count),
        .total_count     (total_count),
        .fatal           (fatal),
        .fatal_worker    (fatal_worker),
        .status          (status),
        .mismatches      (mismatches),
        .outstanding     (outstanding),
        .compared        (compared)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Stall the result channel for a drawn number of cycles after each result
    always @(posedge clk)
    begin
        int hold;
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end
        else if (out_valid && !out_stall)
        begin
            hold = calm ? 0 : $urandom_range(0, 16);
            out_stall  <= (hold != 0);
            stall_left <= hold;
        end
        else if (stall_left > 0)
        begin
            out_stall  <= (stall_left > 1);
            stall_left <= stall_left - 1;
        end
    end

    // Send one request word after a drawn idle gap; return at its accepting edge
    task automatic push_request(input req_t req, input logic [WORKER_W-1:0] w,
                                input logic [GRACE_W-1:0] grace,
                                input logic [GRACE_W-1:0] hard_grace);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 16);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        req_type      <= req;
        worker        <= w;
        grace_ticks   <= grace;
        suicide_ticks <= hard_grace;
        do
            @(posedge clk);
        while (in_stall);
        sent_by_req[req]++;
    endtask

    // Mostly short graces so deadlines expire, plus full-range and extreme values
    function automatic logic [GRACE_W-1:0] draw_grace();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 70)
            return GRACE_W'($urandom_range(0, 30));
        else if (pick < 90)
            return GRACE_W'($urandom);
        else
            return ($urandom_range(0, 1) != 0) ? GRACE_MAX : '0;
    endfunction

    // Hard graces: mostly off or far away, so fatal latches somewhere mid-run
    function automatic logic [GRACE_W-1:0] draw_hard_grace();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 45)
            return '0;
        else if (pick < 95)
            return GRACE_W'($urandom_range(1000, 32'h3FFF_FFFF));
        else
            return GRACE_W'($urandom_range(1, 20));
    endfunction

    initial
    begin
        int   pick;
        req_t req;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        req_type      = REQ_NOP;
        worker        = '0;
        grace_ticks   = '0;
        suicide_ticks = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: bad slots, expiry, injection, extremes, no-op
        push_request(REQ_CHECK, 4'd0, '0, '0);
        push_request(REQ_REMOVE, 4'd0, '0, '0);
        push_request(REQ_ARM, 4'd15, GRACE_MAX, GRACE_MAX);
        push_request(REQ_DISARM, 4'd3, '0, '0);
        push_request(REQ_ADD, 4'd0, '0, '0);
        push_request(REQ_ADD, 4'd0, '0, '0);
        push_request(REQ_ADD, 4'd15, '0, '0);
        push_request(REQ_ARM, 4'd0, '0, '0);
        push_request(REQ_TICK, 4'd0, '0, '0);
        push_request(REQ_CHECK, 4'd0, '0, '0);
        push_request(REQ_ARM, 4'd15, GRACE_MAX, GRACE_MAX);
        push_request(REQ_INJECT, 4'd0, '0, '0);
        push_request(REQ_INJECT, 4'd0, 30'd2, '0);
        push_request(REQ_CHECK, 4'd0, '0, '0);
        repeat (3) push_request(REQ_TICK, 4'd15, GRACE_MAX, GRACE_MAX);
        push_request(REQ_CHECK, 4'd0, '0, '0);
        push_request(REQ_DISARM, 4'd0, '0, '0);
        push_request(REQ_NOP, 4'd9, GRACE_MAX, GRACE_MAX);
        push_request(REQ_REMOVE, 4'd15, '0, '0);
        push_request(REQ_CHECK, 4'd0, '0, '0);

        // Random mix, with stretches of back-to-back traffic
        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            if (n % 32 == 0)
                calm = ($urandom_range(0, 3) == 0);
            pick = $urandom_range(0, 99);
            if (pick < 30)
                req = REQ_TICK;
            else if (pick < 42)
                req = REQ_ADD;
            else if (pick < 49)
                req = REQ_REMOVE;
            else if (pick < 67)
                req = REQ_ARM;
            else if (pick < 73)
                req = REQ_DISARM;
            else if (pick < 89)
                req = REQ_CHECK;
            else if (pick < 96)
                req = REQ_INJECT;
            else
                req = REQ_NOP;
            push_request(req, WORKER_W'($urandom_range(0, 15)), draw_grace(),
                         draw_hard_grace());
        end
        in_valid <= 1'b0;

        // Let the count take in the last word, drain the results, then wait for strays
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        $display("Run covered %0d compared results: %0d ticks, %0d arms, %0d health checks,",
                 compared, sent_by_req[REQ_TICK], sent_by_req[REQ_ARM],
                 sent_by_req[REQ_CHECK]);
        $display("  %0d adds, %0d removes, %0d injects, with random idling on both sides.",
                 sent_by_req[REQ_ADD], sent_by_req[REQ_REMOVE], sent_by_req[REQ_INJECT]);
        if (mismatches == 0 && outstanding == 0)
            $display("PASS worker_heartbeat_watchdog");
        else
            $display("FAIL worker_heartbeat_watchdog");
        $finish;
    end

    // Stop a hung run
    initial
    begin
        #5ms;
        $display("FAIL worker_heartbeat_watchdog");
        $finish;
    end

endmodule

>>> sim.f
rtl/whw_pkg.sv
rtl/whw_ctrl.sv
rtl/whw_dp.sv
rtl/worker_heartbeat_watchdog.sv
tb/worker_heartbeat_watchdog_chk.sv
tb/worker_heartbeat_watchdog_tb.sv
